>>> design/wws_pkg.sv
// shared constants, types and codes of the window weighted sum block
package wws_pkg;

  localparam int RADIUS   = 3;
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 4096;
  localparam int DIAM     = 2 * RADIUS + 1;
  localparam int LINES    = 2 * RADIUS;
  localparam int NTAPS    = DIAM * DIAM;

  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int OP_W   = 1;
  localparam int WIDX_W = 6;
  localparam int GOOD_W = 40;
  localparam int ROWO_W = 12;
  localparam int COLO_W = 10;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  localparam int CFG_COLS_W   = 11;
  localparam int CFG_ROWS_W   = 13;
  localparam int CFG_BORDER_W = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  localparam int COLS_CMP_W = ((COL_W + 1 > CFG_COLS_W) ? COL_W + 1 : CFG_COLS_W) + 1;
  localparam int ROWS_CMP_W = CFG_ROWS_W + 1;

  localparam int ROWSUM_W    = PROD_W + $clog2(DIAM);
  localparam int SUM_W       = ROWSUM_W + $clog2(DIAM);
  localparam int LINE_WORD_W = LINES * DATA_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_WEIGHT = 1'b0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH = 2'd2;

  localparam logic [CFG_COLS_W-1:0]   GRID_COLS_RST    = 11'd1024;
  localparam logic [CFG_ROWS_W-1:0]   GRID_ROWS_RST    = 13'd4096;
  localparam logic [CFG_BORDER_W-1:0] BORDER_WIDTH_RST = 8'd3;

  typedef logic [DIAM-1:0][DATA_W-1:0] column_t;

  typedef struct packed {
    logic              valid;
    logic              is_sample;
    logic              hit;
    logic [COL_W-1:0]  addr;
    logic [ROWO_W-1:0] center_row;
    logic [COLO_W-1:0] center_col;
    logic [WIDX_W-1:0] widx;
    logic [DATA_W-1:0] wval;
    logic [DATA_W-1:0] sample;
  } stage_t;

  typedef struct packed {
    logic [GOOD_W-1:0] goodness;
    logic [ROWO_W-1:0] center_row;
    logic [COLO_W-1:0] center_col;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_req_t;

endpackage

>>> design/wws_item_if.sv
// input request channel: kernel weight writes and grid samples
interface wws_item_if;
  logic                           valid;
  logic                           ready;
  logic [wws_pkg::OP_W-1:0]       op;
  logic [wws_pkg::WIDX_W-1:0]     weight_index;
  logic [wws_pkg::DATA_W-1:0]     weight_value;
  logic [wws_pkg::DATA_W-1:0]     sample;

  modport source(output valid, op, weight_index, weight_value, sample, input ready);
  modport sink(input valid, op, weight_index, weight_value, sample, output ready);
endinterface

>>> design/wws_result_if.sv
// result request channel: weighted window sums with their cell position
interface wws_result_if;
  logic                        valid;
  logic                        ready;
  logic [wws_pkg::GOOD_W-1:0]  goodness;
  logic [wws_pkg::ROWO_W-1:0]  center_row;
  logic [wws_pkg::COLO_W-1:0]  center_col;

  modport source(output valid, goodness, center_row, center_col, input ready);
  modport sink(input valid, goodness, center_row, center_col, output ready);
endinterface

>>> design/wws_cfg_if.sv
// configuration write channel
interface wws_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wws_pkg::CFG_IDX_W-1:0]   index;
  logic [wws_pkg::CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> design/wws_mac.sv
// window registers, kernel weights and the pipelined multiply-add tree
module wws_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  wws_pkg::stage_t      st,
  input  wws_pkg::column_t     column,
  output wws_pkg::result_req_t res
);

  logic [wws_pkg::DIAM-1:0][wws_pkg::DIAM-1:0][wws_pkg::DATA_W-1:0] win;
  logic [wws_pkg::DIAM-1:0][wws_pkg::DIAM-1:0][wws_pkg::DATA_W-1:0] kernel;
  logic [wws_pkg::DIAM-1:0][wws_pkg::DIAM-1:0][wws_pkg::PROD_W-1:0] prod;
  logic [wws_pkg::DIAM-1:0][wws_pkg::ROWSUM_W-1:0]                  rowsum;
  logic [wws_pkg::DIAM-1:0][wws_pkg::ROWSUM_W-1:0]                  rowsum_next;
  logic [wws_pkg::SUM_W-1:0]                                        total_next;

  logic                        shift_en;
  logic                        w_en;
  logic                        w_vld;
  logic                        p_vld;
  logic                        r_vld;
  logic [wws_pkg::ROWO_W-1:0]  w_row;
  logic [wws_pkg::ROWO_W-1:0]  p_row;
  logic [wws_pkg::ROWO_W-1:0]  r_row;
  logic [wws_pkg::COLO_W-1:0]  w_col;
  logic [wws_pkg::COLO_W-1:0]  p_col;
  logic [wws_pkg::COLO_W-1:0]  r_col;

  assign shift_en = st.valid && st.is_sample;
  assign w_en     = st.valid && !st.is_sample && (int'(st.widx) < wws_pkg::NTAPS);

  // window shifts left, new column enters at the right
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (shift_en) begin
      for (int i = 0; i < wws_pkg::DIAM; i++) begin
        for (int j = 0; j < wws_pkg::DIAM - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
        win[i][wws_pkg::DIAM-1] <= column[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < wws_pkg::DIAM; i++) begin
      for (int j = 0; j < wws_pkg::DIAM; j++) begin
        if (w_en && (int'(st.widx) == i * wws_pkg::DIAM + j)) begin
          kernel[i][j] <= st.wval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_vld     <= 1'b0;
      p_vld     <= 1'b0;
      r_vld     <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      w_vld     <= shift_en && st.hit;
      p_vld     <= w_vld;
      r_vld     <= p_vld;
      res.valid <= r_vld;
    end
    w_row <= st.center_row;
    w_col <= st.center_col;
    for (int i = 0; i < wws_pkg::DIAM; i++) begin
      for (int j = 0; j < wws_pkg::DIAM; j++) begin
        prod[i][j] <= wws_pkg::PROD_W'(win[i][j]) * wws_pkg::PROD_W'(kernel[i][j]);
      end
    end
    p_row  <= w_row;
    p_col  <= w_col;
    rowsum <= rowsum_next;
    r_row  <= p_row;
    r_col  <= p_col;
    res.data.goodness   <= wws_pkg::GOOD_W'(total_next);
    res.data.center_row <= r_row;
    res.data.center_col <= r_col;
  end

  always_comb begin
    for (int i = 0; i < wws_pkg::DIAM; i++) begin
      rowsum_next[i] = '0;
      for (int j = 0; j < wws_pkg::DIAM; j++) begin
        rowsum_next[i] = rowsum_next[i] + wws_pkg::ROWSUM_W'(prod[i][j]);
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int i = 0; i < wws_pkg::DIAM; i++) begin
      total_next = total_next + wws_pkg::SUM_W'(rowsum[i]);
    end
  end

endmodule

>>> design/window_weighted_sum_2d.sv
// top level of the streaming 2-d weighted window sum
//
// items carries kernel weight writes (op 0) and grid samples (op 1) in
// row-major order; results carries one weighted sum for each interior cell,
// with the row and column of that cell. cfg writes grid_cols, grid_rows and
// border_width and is always ready; write it only while the block is idle.
// An item is taken every cycle while items.ready is high. A result passes
// these registers after the sample that completes its window: line store
// read, window shift, multipliers, row sums, final sum, output queue. The
// line store is one 1024-word memory holding the six previous rows of a
// column, read at the sample's column and written back in the next cycle;
// a write is forwarded to a read of the same column in the next cycle.
// Results wait in an 8-entry output queue. items.ready drops while 8 results
// are due from accepted samples but not yet taken, so a stalled receiver
// holds the input back and no result is lost.
// Reset sets the registers to their reset values, the position to row 0,
// column 0, clears the window and empties the queue. The line store and the
// kernel weights are not cleared: load every weight before sending samples.
module window_weighted_sum_2d (
  input logic          clk,
  input logic          rst,
  wws_item_if.sink     items,
  wws_result_if.source results,
  wws_cfg_if.sink      cfg
);

  logic [wws_pkg::CFG_COLS_W-1:0]   grid_cols;
  logic [wws_pkg::CFG_ROWS_W-1:0]   grid_rows;
  logic [wws_pkg::CFG_BORDER_W-1:0] border_width;

  logic [wws_pkg::COLS_CMP_W-1:0]   cols_eff;
  logic [wws_pkg::ROWS_CMP_W-1:0]   rows_eff;
  logic [wws_pkg::CFG_BORDER_W-1:0] b_eff;
  logic [wws_pkg::COLS_CMP_W-1:0]   gc_ext;
  logic [wws_pkg::ROWS_CMP_W-1:0]   gr_ext;

  logic [wws_pkg::ROW_W-1:0]        row_count;
  logic [wws_pkg::COL_W-1:0]        col_count;
  logic [wws_pkg::ROW_W-1:0]        row_count_next;
  logic [wws_pkg::COL_W-1:0]        col_count_next;
  logic [wws_pkg::ROW_W-1:0]        cr;
  logic [wws_pkg::COL_W-1:0]        cc;
  logic [wws_pkg::COLS_CMP_W-1:0]   col_inc;
  logic [wws_pkg::ROWS_CMP_W-1:0]   row_inc;
  logic                             hit;

  logic                             in_acc;
  logic                             is_sample;
  wws_pkg::stage_t                  s0;
  wws_pkg::stage_t                  s1;

  logic [wws_pkg::LINE_WORD_W-1:0]  line_mem [wws_pkg::MAX_COLS];
  logic [wws_pkg::LINE_WORD_W-1:0]  rd_word;
  logic [wws_pkg::LINE_WORD_W-1:0]  src_word;
  logic [wws_pkg::LINE_WORD_W-1:0]  new_word;
  logic [wws_pkg::LINE_WORD_W-1:0]  wr_word_q;
  logic [wws_pkg::COL_W-1:0]        wr_addr_q;
  logic                             wr_vld_q;
  logic                             wr_en;
  wws_pkg::column_t                 column;

  wws_pkg::result_req_t             res;
  wws_pkg::result_t                 fifo_mem [wws_pkg::FIFO_DEPTH];
  logic [wws_pkg::FIFO_AW-1:0]      wr_ptr;
  logic [wws_pkg::FIFO_AW-1:0]      rd_ptr;
  logic [wws_pkg::PEND_W-1:0]       fcount;
  logic [wws_pkg::PEND_W-1:0]       pending;
  logic                             pop;
  logic                             pend_inc;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols    <= wws_pkg::GRID_COLS_RST;
      grid_rows    <= wws_pkg::GRID_ROWS_RST;
      border_width <= wws_pkg::BORDER_WIDTH_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        wws_pkg::REG_GRID_COLS:    grid_cols    <= cfg.data[wws_pkg::CFG_COLS_W-1:0];
        wws_pkg::REG_GRID_ROWS:    grid_rows    <= cfg.data[wws_pkg::CFG_ROWS_W-1:0];
        wws_pkg::REG_BORDER_WIDTH: border_width <= cfg.data[wws_pkg::CFG_BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gc_ext = wws_pkg::COLS_CMP_W'(grid_cols);
    gr_ext = wws_pkg::ROWS_CMP_W'(grid_rows);
    if (gc_ext == '0) begin
      cols_eff = wws_pkg::COLS_CMP_W'(1);
    end else if (gc_ext > wws_pkg::COLS_CMP_W'(wws_pkg::MAX_COLS)) begin
      cols_eff = wws_pkg::COLS_CMP_W'(wws_pkg::MAX_COLS);
    end else begin
      cols_eff = gc_ext;
    end
    if (gr_ext == '0) begin
      rows_eff = wws_pkg::ROWS_CMP_W'(1);
    end else if (gr_ext > wws_pkg::ROWS_CMP_W'(wws_pkg::MAX_ROWS)) begin
      rows_eff = wws_pkg::ROWS_CMP_W'(wws_pkg::MAX_ROWS);
    end else begin
      rows_eff = gr_ext;
    end
    if (border_width < wws_pkg::CFG_BORDER_W'(wws_pkg::RADIUS)) begin
      b_eff = wws_pkg::CFG_BORDER_W'(wws_pkg::RADIUS);
    end else begin
      b_eff = border_width;
    end
  end

  // raster position and interior test
  assign in_acc    = items.valid && items.ready;
  assign is_sample = (items.op == wws_pkg::OP_SAMPLE);
  assign cr        = row_count - wws_pkg::ROW_W'(wws_pkg::RADIUS);
  assign cc        = col_count - wws_pkg::COL_W'(wws_pkg::RADIUS);

  assign hit = (row_count >= wws_pkg::ROW_W'(wws_pkg::RADIUS)) &&
               (col_count >= wws_pkg::COL_W'(wws_pkg::RADIUS)) &&
               (wws_pkg::ROWS_CMP_W'(cr) >= wws_pkg::ROWS_CMP_W'(b_eff)) &&
               (wws_pkg::ROWS_CMP_W'(cr) + wws_pkg::ROWS_CMP_W'(b_eff) < rows_eff) &&
               (wws_pkg::COLS_CMP_W'(cc) >= wws_pkg::COLS_CMP_W'(b_eff)) &&
               (wws_pkg::COLS_CMP_W'(cc) + wws_pkg::COLS_CMP_W'(b_eff) < cols_eff);

  always_comb begin
    col_inc        = wws_pkg::COLS_CMP_W'(col_count) + wws_pkg::COLS_CMP_W'(1);
    row_inc        = wws_pkg::ROWS_CMP_W'(row_count) + wws_pkg::ROWS_CMP_W'(1);
    row_count_next = row_count;
    col_count_next = wws_pkg::COL_W'(col_inc);
    if (col_inc >= cols_eff) begin
      col_count_next = '0;
      if (row_inc >= rows_eff) begin
        row_count_next = '0;
      end else begin
        row_count_next = wws_pkg::ROW_W'(row_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_acc && is_sample) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  always_comb begin
    s0.valid      = in_acc;
    s0.is_sample  = is_sample;
    s0.hit        = hit;
    s0.addr       = col_count;
    s0.center_row = wws_pkg::ROWO_W'(cr);
    s0.center_col = wws_pkg::COLO_W'(cc);
    s0.widx       = items.weight_index;
    s0.wval       = items.weight_value;
    s0.sample     = items.sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1 <= s0;
    end
  end

  // line store: read at the current column, write back in the next cycle
  assign wr_en    = s1.valid && s1.is_sample;
  assign src_word = (wr_vld_q && (wr_addr_q == s1.addr)) ? wr_word_q : rd_word;
  assign new_word = {s1.sample, src_word[wws_pkg::LINE_WORD_W-1:wws_pkg::DATA_W]};

  always_comb begin
    for (int i = 0; i < wws_pkg::LINES; i++) begin
      column[i] = src_word[i*wws_pkg::DATA_W +: wws_pkg::DATA_W];
    end
    column[wws_pkg::LINES] = s1.sample;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s1.addr] <= new_word;
    end
    rd_word <= line_mem[col_count];
  end

  always_ff @(posedge clk) begin
    wr_addr_q <= s1.addr;
    wr_word_q <= new_word;
    if (rst) begin
      wr_vld_q <= 1'b0;
    end else begin
      wr_vld_q <= wr_en;
    end
  end

  wws_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .st     (s1),
    .column (column),
    .res    (res)
  );

  // output queue with a credit taken for each accepted sample that hits
  assign pop      = results.valid && results.ready;
  assign pend_inc = in_acc && is_sample && hit;

  assign items.ready        = (pending < wws_pkg::PEND_W'(wws_pkg::FIFO_DEPTH));
  assign results.valid      = (fcount != '0);
  assign results.goodness   = fifo_mem[rd_ptr].goodness;
  assign results.center_row = fifo_mem[rd_ptr].center_row;
  assign results.center_col = fifo_mem[rd_ptr].center_col;

  always_ff @(posedge clk) begin
    if (res.valid) begin
      fifo_mem[wr_ptr] <= res.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fcount  <= '0;
      pending <= '0;
    end else begin
      if (res.valid) begin
        wr_ptr <= wr_ptr + wws_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + wws_pkg::FIFO_AW'(1);
      end
      fcount  <= fcount + wws_pkg::PEND_W'(res.valid) - wws_pkg::PEND_W'(pop);
      pending <= pending + wws_pkg::PEND_W'(pend_inc) - wws_pkg::PEND_W'(pop);
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= wws_pkg::PEND_W'(wws_pkg::FIFO_DEPTH))
    else $error("pending results exceed queue depth");

  a_queue_le_pend: assert property (@(posedge clk) disable iff (rst)
    fcount <= pending)
    else $error("queue holds more results than were credited");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (fcount < pending))
    else $error("result pushed without credit");

  a_weight_no_credit: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (items.op == wws_pkg::OP_WEIGHT)) |=> (pending <= $past(pending)))
    else $error("weight write took a result credit");

endmodule

>>> verif/tb_top.sv
// testbench for window_weighted_sum_2d: streamed grids checked against a window-sum predictor
`timescale 1ns / 100ps

module tb_top;

  localparam logic [wws_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_REQS   = 40;
  localparam int HOLD_CYCLES   = 200;

  logic clk;
  logic rst;

  wws_item_if   item_ch();
  wws_result_if res_ch();
  wws_cfg_if    cfg_ch();

  window_weighted_sum_2d u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  // predictor state
  logic [wws_pkg::DATA_W-1:0]       line_mem [wws_pkg::LINES][wws_pkg::MAX_COLS];
  logic [wws_pkg::DATA_W-1:0]       taps [wws_pkg::NTAPS];
  logic [wws_pkg::DATA_W-1:0]       win [wws_pkg::DIAM][wws_pkg::DIAM];
  int unsigned                      row_pos;
  int unsigned                      col_pos;
  logic [wws_pkg::CFG_COLS_W-1:0]   cols_reg;
  logic [wws_pkg::CFG_ROWS_W-1:0]   rows_reg;
  logic [wws_pkg::CFG_BORDER_W-1:0] border_reg;

  wws_pkg::result_t sums_due[$];

  int  fail_count;
  int  sums_checked;
  int  live_requests;
  int  grid_settings;
  int  quiet_cycles;
  int  hold_req;
  int  hold_left;
  bit  src_gaps;
  bit  sink_gaps;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic slide_window(input logic [wws_pkg::DATA_W-1:0] smp);
    logic [wws_pkg::DATA_W-1:0] col [wws_pkg::DIAM];
    int unsigned cols;
    int unsigned rows;
    int unsigned bord;
    int unsigned cr;
    int unsigned cc;
    logic [63:0] acc;
    wws_pkg::result_t sum;
    cols = (cols_reg == 0) ? 1 :
           (cols_reg > wws_pkg::MAX_COLS) ? wws_pkg::MAX_COLS : cols_reg;
    rows = (rows_reg == 0) ? 1 :
           (rows_reg > wws_pkg::MAX_ROWS) ? wws_pkg::MAX_ROWS : rows_reg;
    bord = (border_reg < wws_pkg::RADIUS) ? wws_pkg::RADIUS : border_reg;
    for (int i = 0; i < wws_pkg::LINES; i++) col[i] = line_mem[i][col_pos];
    col[wws_pkg::LINES] = smp;
    for (int i = 0; i < wws_pkg::LINES; i++) line_mem[i][col_pos] = col[i+1];
    for (int i = 0; i < wws_pkg::DIAM; i++) begin
      for (int j = 0; j < wws_pkg::DIAM - 1; j++) win[i][j] = win[i][j+1];
      win[i][wws_pkg::DIAM-1] = col[i];
    end
    if (row_pos >= wws_pkg::RADIUS && col_pos >= wws_pkg::RADIUS) begin
      cr = row_pos - wws_pkg::RADIUS;
      cc = col_pos - wws_pkg::RADIUS;
      if (cr >= bord && cr + bord < rows && cc >= bord && cc + bord < cols) begin
        acc = '0;
        for (int i = 0; i < wws_pkg::DIAM; i++)
          for (int j = 0; j < wws_pkg::DIAM; j++)
            acc = acc + win[i][j] * taps[i*wws_pkg::DIAM+j];
        sum.goodness   = acc[wws_pkg::GOOD_W-1:0];
        sum.center_row = cr[wws_pkg::ROWO_W-1:0];
        sum.center_col = cc[wws_pkg::COLO_W-1:0];
        sums_due.push_back(sum);
      end
    end
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) row_pos = 0;
    end
  endtask

  // valid stays high after acceptance so back-to-back requests need no toggle
  task automatic send_request(input logic [wws_pkg::OP_W-1:0] op,
                              input logic [wws_pkg::WIDX_W-1:0] widx,
                              input logic [wws_pkg::DATA_W-1:0] wval,
                              input logic [wws_pkg::DATA_W-1:0] smp);
    if (src_gaps && $urandom_range(99) < 20) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.op           <= op;
    item_ch.weight_index <= widx;
    item_ch.weight_value <= wval;
    item_ch.sample       <= smp;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (op == wws_pkg::OP_WEIGHT) begin
      if (widx < wws_pkg::NTAPS) begin
        taps[widx] = wval;
        live_requests++;
      end
    end else begin
      slide_window(smp);
      live_requests++;
    end
  endtask

  task automatic send_weight(input logic [wws_pkg::WIDX_W-1:0] widx,
                             input logic [wws_pkg::DATA_W-1:0] wval);
    logic [wws_pkg::DATA_W-1:0] junk;
    junk = wws_pkg::DATA_W'($urandom_range(16'hFFFF));
    send_request(wws_pkg::OP_WEIGHT, widx, wval, junk);
  endtask

  // level < 0 gives random samples; weight_pct mixes in weight updates
  task automatic stream_samples(input int n, input int level, input int weight_pct);
    logic [wws_pkg::WIDX_W-1:0] widx;
    logic [wws_pkg::DATA_W-1:0] wval;
    logic [wws_pkg::DATA_W-1:0] smp;
    int sent;
    sent = 0;
    while (sent < n) begin
      widx = wws_pkg::WIDX_W'($urandom_range(63));
      wval = wws_pkg::DATA_W'($urandom_range(16'hFFFF));
      if ($urandom_range(99) < weight_pct) begin
        send_request(wws_pkg::OP_WEIGHT, widx, wval, wval);
      end else begin
        smp = (level < 0) ? wws_pkg::DATA_W'($urandom_range(16'hFFFF)) :
                            wws_pkg::DATA_W'(level);
        send_request(wws_pkg::OP_SAMPLE, widx, wval, smp);
        sent++;
      end
    end
  endtask

  task automatic load_kernel(input int level);
    logic [wws_pkg::DATA_W-1:0] wval;
    for (int i = 0; i < wws_pkg::NTAPS; i++) begin
      wval = (level < 0) ? wws_pkg::DATA_W'($urandom_range(16'hFFFF)) :
                           wws_pkg::DATA_W'(level);
      send_weight(wws_pkg::WIDX_W'(i), wval);
    end
  endtask

  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wws_pkg::CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      wws_pkg::REG_GRID_COLS:    cols_reg = data[wws_pkg::CFG_COLS_W-1:0];
      wws_pkg::REG_GRID_ROWS:    rows_reg = data[wws_pkg::CFG_ROWS_W-1:0];
      wws_pkg::REG_BORDER_WIDTH: border_reg = data[wws_pkg::CFG_BORDER_W-1:0];
      default: ;
    endcase
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_grid(input logic [wws_pkg::CFG_DATA_W-1:0] cols,
                          input logic [wws_pkg::CFG_DATA_W-1:0] rows,
                          input logic [wws_pkg::CFG_DATA_W-1:0] bord);
    wait_idle();
    write_reg(wws_pkg::REG_GRID_COLS, cols, 1'b0);
    write_reg(wws_pkg::REG_GRID_ROWS, rows, 1'b0);
    write_reg(wws_pkg::REG_BORDER_WIDTH, bord, 1'b1);
    grid_settings++;
  endtask

  // index edges, then an all-ones kernel
  task automatic test_kernel_load();
    send_weight(wws_pkg::WIDX_W'(0), 16'h0000);
    send_weight(wws_pkg::WIDX_W'(wws_pkg::NTAPS - 1), 16'hFFFF);
    load_kernel(16'hFFFF);
    // indexes past the kernel are dropped
    send_weight(wws_pkg::WIDX_W'(wws_pkg::NTAPS), 16'h0000);
    send_weight(6'd63, 16'h0000);
  endtask

  task automatic test_saturated_window();
    set_grid(13'd7, 13'd7, 13'd3);
    stream_samples(49, 16'hFFFF, 0);
    load_kernel(-1);
  endtask

  // no idling on either side; also fills every line store column used later
  task automatic test_full_rate();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    set_grid(13'd12, 13'd8, 13'd0);
    stream_samples(96, -1, 0);
    wait_idle();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_clamped_grid();
    wait_idle();
    write_reg(REG_SPARE, 13'h1FFF, 1'b0);
    write_reg(wws_pkg::REG_GRID_COLS, 13'h1FFF, 1'b0);
    write_reg(wws_pkg::REG_GRID_ROWS, 13'h1FFF, 1'b0);
    write_reg(wws_pkg::REG_BORDER_WIDTH, 13'h0FF, 1'b1);
    grid_settings++;
    stream_samples(12, -1, 0);
    set_grid(13'd0, 13'd0, 13'd255);
    stream_samples(6, -1, 0);
  endtask

  task automatic test_midgrid_change();
    set_grid(13'd12, 13'd10, 13'd3);
    stream_samples(70, -1, 0);
    // column count now past the narrower width
    wait_idle();
    write_reg(wws_pkg::REG_GRID_COLS, 13'd8, 1'b1);
    stream_samples(30, -1, 0);
    wait_idle();
    write_reg(wws_pkg::REG_BORDER_WIDTH, 13'd4, 1'b0);
    write_reg(wws_pkg::REG_GRID_ROWS, 13'd7, 1'b1);
    stream_samples(20, -1, 0);
  endtask

  task automatic test_backpressure();
    set_grid(13'd12, 13'd10, 13'd3);
    src_gaps = 1'b0;
    hold_req = HOLD_CYCLES;
    stream_samples(120, -1, 3);
    src_gaps = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_grids();
    int start;
    int pick;
    int cols;
    int rows;
    int bord;
    int cells;
    start = live_requests;
    while (live_requests - start < RANDOM_REQS) begin
      cols = $urandom_range(7, 12);
      rows = $urandom_range(7, 12);
      pick = $urandom_range(99);
      if (pick < 60)      bord = $urandom_range(0, 3);
      else if (pick < 85) bord = $urandom_range(4, 5);
      else if (pick < 95) bord = $urandom_range(6, 254);
      else                bord = 255;
      set_grid(wws_pkg::CFG_DATA_W'(cols), wws_pkg::CFG_DATA_W'(rows),
               wws_pkg::CFG_DATA_W'(bord));
      cells = cols * rows;
      // some grids are cut short so the next setting lands mid-grid
      if ($urandom_range(9) == 0) cells = $urandom_range(1, cells - 1);
      stream_samples(cells, -1, 5);
    end
  endtask

  initial begin
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.op           = wws_pkg::OP_WEIGHT;
    item_ch.weight_index = '0;
    item_ch.weight_value = '0;
    item_ch.sample       = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = wws_pkg::REG_GRID_COLS;
    cfg_ch.data          = '0;
    cols_reg   = wws_pkg::GRID_COLS_RST;
    rows_reg   = wws_pkg::GRID_ROWS_RST;
    border_reg = wws_pkg::BORDER_WIDTH_RST;
    row_pos = 0;
    col_pos = 0;
    for (int i = 0; i < wws_pkg::LINES; i++)
      for (int j = 0; j < wws_pkg::MAX_COLS; j++) line_mem[i][j] = '0;
    for (int i = 0; i < wws_pkg::NTAPS; i++) taps[i] = '0;
    for (int i = 0; i < wws_pkg::DIAM; i++)
      for (int j = 0; j < wws_pkg::DIAM; j++) win[i][j] = '0;
    fail_count    = 0;
    sums_checked  = 0;
    live_requests = 0;
    grid_settings = 0;
    src_gaps      = 1'b1;
    sink_gaps     = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_kernel_load();
    test_saturated_window();
    test_full_rate();
    test_clamped_grid();
    test_midgrid_change();
    test_backpressure();
    test_random_grids();
    wait_idle();

    $display("%0d requests sent, %0d window sums checked over %0d grid settings",
             live_requests, sums_checked, grid_settings);
    $display("kernel index edges, saturated sums, clamped sizes, borders 0 to 255, %s",
             "mid-grid changes, full-rate runs and a long receiver stall");
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // receiver side, with long hold-offs on request
  initial begin
    hold_req  = 0;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (sink_gaps && $urandom_range(99) < 25) begin
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_sums
    wws_pkg::result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      sums_checked++;
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected sum %h at row %0d col %0d", $time,
                 res_ch.goodness, res_ch.center_row, res_ch.center_col);
        fail_count++;
      end else begin
        want = sums_due.pop_front();
        if (res_ch.goodness !== want.goodness) begin
          $display("%0t: goodness expected %h actual %h", $time, want.goodness, res_ch.goodness);
          fail_count++;
        end
        if (res_ch.center_row !== want.center_row) begin
          $display("%0t: center_row expected %0d actual %0d", $time,
                   want.center_row, res_ch.center_row);
          fail_count++;
        end
        if (res_ch.center_col !== want.center_col) begin
          $display("%0t: center_col expected %0d actual %0d", $time,
                   want.center_col, res_ch.center_col);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: nothing moved for %0d cycles, %0d sums still due", $time,
                 quiet_cycles, sums_due.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
design/wws_pkg.sv
design/wws_item_if.sv
design/wws_result_if.sv
design/wws_cfg_if.sv
design/wws_mac.sv
design/window_weighted_sum_2d.sv
verif/tb_top.sv
